// ===== src/ppmd_pkg.sv =====
// Shared constants, register codes and store access types for the PPM frame decoder.
// No dependencies.
package ppmd_pkg;

  localparam int CHANNELS_DEFAULT = 8;
  localparam int CH_IDX_W         = 4;
  localparam int TIME_W           = 32;
  localparam int VALUE_W          = 27;
  localparam int CHAN_W           = 8;
  localparam int PADDR_W          = 4;

  localparam logic [1:0] REG_SYNC_MIN  = 2'd0;
  localparam logic [1:0] REG_SYNC_MAX  = 2'd1;
  localparam logic [1:0] REG_PULSE_MIN = 2'd2;
  localparam logic [1:0] REG_PULSE_MAX = 2'd3;

  localparam logic [TIME_W-1:0] SYNC_MIN_RESET  = 32'd250000;
  localparam logic [TIME_W-1:0] SYNC_MAX_RESET  = 32'd750000;
  localparam logic [TIME_W-1:0] PULSE_MIN_RESET = 32'd45000;
  localparam logic [TIME_W-1:0] PULSE_MAX_RESET = 32'd105000;

  // x / 50 == (x * DIV_MULT) >> DIV_SHIFT for every 32-bit x
  localparam logic [31:0] DIV_MULT  = 32'd2748779070;
  localparam int          DIV_SHIFT = 37;

  localparam logic [VALUE_W-1:0] NEUTRAL_READ = 27'd1500;

  typedef struct packed {
    logic                en;
    logic [CH_IDX_W-1:0] addr;
    logic [TIME_W-1:0]   data;
  } store_wr_t;

  typedef struct packed {
    logic                en;
    logic [CH_IDX_W-1:0] addr;
  } store_rd_t;

endpackage

// ===== src/ppmd_if.sv =====
// Valid/ready channel interfaces for decoder requests and responses.
// Depends on ppmd_pkg.
interface ppmd_req_if;
  import ppmd_pkg::*;
  logic                func;
  logic [TIME_W-1:0]   capture_time;
  logic [CHAN_W-1:0]   channel;
  logic                valid;
  logic                ready;
  modport source (output valid, func, capture_time, channel, input ready);
  modport sink   (input valid, func, capture_time, channel, output ready);
endinterface

interface ppmd_rsp_if;
  import ppmd_pkg::*;
  logic [VALUE_W-1:0]  channel_value;
  logic                locked;
  logic [TIME_W-1:0]   interval;
  logic                valid;
  logic                ready;
  modport source (output valid, channel_value, locked, interval, input ready);
  modport sink   (input valid, channel_value, locked, interval, output ready);
endinterface

// ===== src/ppmd_chan_store.sv =====
// Channel width memory: one write port, one registered read port, per-entry valid bits.
// Depends on ppmd_pkg.
module ppmd_chan_store #(
  parameter int CHANNELS = ppmd_pkg::CHANNELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ppmd_pkg::store_wr_t           wr,
  input  ppmd_pkg::store_rd_t           rd,
  output logic [ppmd_pkg::TIME_W-1:0]   rd_data
);
  import ppmd_pkg::*;

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [TIME_W-1:0]   mem [CHANNELS];
  logic [CHANNELS-1:0] written;
  logic [TIME_W-1:0]   q;
  logic                q_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
    if (rd.en) begin
      q <= mem[rd.addr[AW-1:0]];
    end
  end

  // unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      q_hit   <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.addr[AW-1:0]] <= 1'b1;
      end
      if (rd.en) begin
        q_hit <= written[rd.addr[AW-1:0]];
      end
    end
  end

  assign rd_data = q_hit ? q : '0;

endmodule

// ===== src/ppm_frame_decoder_core.sv =====
// PPM frame decoder top level: APB registers, position machine and response pipeline.
// Depends on ppmd_pkg, ppmd_if and ppmd_chan_store.
//
// Accepts one request per clock cycle while the response side is not stalled, and
// returns one response for each through stage 1 and the output stage. Edge requests
// update the position machine and previous edge time in the cycle they are accepted,
// so back-to-back edges chain without bubbles. Channel widths live in a CHANNELS-entry
// memory with a registered read; a read request's stored width is scaled by 1/50 with
// a constant multiply registered into the output stage. Reset clears the store at once
// through per-entry valid bits, so no clearing pass is needed.
module ppm_frame_decoder_core #(
  parameter int CHANNELS = ppmd_pkg::CHANNELS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  ppmd_req_if.sink                      req,
  ppmd_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import ppmd_pkg::*;

  localparam int PW = $clog2(CHANNELS + 3);
  localparam logic [PW-1:0] POS_LAST   = PW'(CHANNELS);
  localparam logic [PW-1:0] POS_WAIT   = PW'(CHANNELS + 1);
  localparam logic [PW-1:0] POS_UNSYNC = PW'(CHANNELS + 2);

  logic [TIME_W-1:0] sync_min, sync_max, pulse_min, pulse_max;
  logic [PW-1:0]     position, position_next;
  logic [TIME_W-1:0] previous_edge;
  logic [TIME_W-1:0] gap;
  logic              is_sync, is_pulse;
  logic              req_xfer, edge_xfer, read_xfer;
  logic              adv_out;
  store_wr_t         wr;
  store_rd_t         rd;
  logic [TIME_W-1:0] store_q;
  logic [63:0]       prod;
  logic [VALUE_W-1:0] value;

  logic              s1_valid;
  logic              s1_func;
  logic              s1_oor;
  logic              s1_locked;
  logic [TIME_W-1:0] s1_interval;

  logic               out_valid;
  logic [VALUE_W-1:0] out_value;
  logic               out_locked;
  logic [TIME_W-1:0]  out_interval;

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_min  <= SYNC_MIN_RESET;
      sync_max  <= SYNC_MAX_RESET;
      pulse_min <= PULSE_MIN_RESET;
      pulse_max <= PULSE_MAX_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_SYNC_MIN:  sync_min  <= pwdata;
        REG_SYNC_MAX:  sync_max  <= pwdata;
        REG_PULSE_MIN: pulse_min <= pwdata;
        REG_PULSE_MAX: pulse_max <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_SYNC_MIN:  prdata = sync_min;
      REG_SYNC_MAX:  prdata = sync_max;
      REG_PULSE_MIN: prdata = pulse_min;
      REG_PULSE_MAX: prdata = pulse_max;
      default:       prdata = '0;
    endcase
  end

  // handshake
  assign adv_out   = !out_valid || rsp.ready;
  assign req.ready = !s1_valid || adv_out;
  assign req_xfer  = req.valid && req.ready;
  assign edge_xfer = req_xfer && !req.func;
  assign read_xfer = req_xfer && req.func;

  // position machine
  assign gap      = req.capture_time - previous_edge;
  assign is_sync  = (gap >= sync_min) && (gap <= sync_max);
  assign is_pulse = (gap >= pulse_min) && (gap <= pulse_max);

  always_comb begin
    position_next = position;
    wr.en   = 1'b0;
    wr.addr = '0;
    wr.data = gap;
    if (position >= POS_UNSYNC) begin
      position_next = is_sync ? POS_WAIT : POS_UNSYNC;
    end else if (position == POS_WAIT) begin
      if (is_pulse) begin
        wr.en         = edge_xfer;
        position_next = PW'(1);
      end else begin
        position_next = POS_UNSYNC;
      end
    end else if (position == POS_LAST) begin
      position_next = is_sync ? POS_WAIT : POS_UNSYNC;
    end else begin
      // middle pulse: bad widths are skipped but still advance
      wr.en         = edge_xfer && is_pulse;
      wr.addr       = CH_IDX_W'(position);
      position_next = position + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= POS_UNSYNC;
      previous_edge <= '0;
    end else if (edge_xfer) begin
      position      <= position_next;
      previous_edge <= req.capture_time;
    end
  end

  assign rd.en   = read_xfer && (req.channel < CHAN_W'(CHANNELS));
  assign rd.addr = req.channel[CH_IDX_W-1:0];

  ppmd_chan_store #(
    .CHANNELS (CHANNELS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd      (rd),
    .rd_data (store_q)
  );

  // stage 1: waits on the store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      s1_func     <= req.func;
      s1_oor      <= req.channel >= CHAN_W'(CHANNELS);
      s1_locked   <= req.func ? (position < POS_UNSYNC) : (position_next < POS_UNSYNC);
      s1_interval <= req.func ? '0 : gap;
    end
  end

  // divide by 50 through reciprocal multiply
  assign prod = 64'(store_q) * 64'(DIV_MULT);

  always_comb begin
    if (!s1_func) begin
      value = '0;
    end else if (s1_oor) begin
      value = NEUTRAL_READ;
    end else begin
      value = prod[DIV_SHIFT+VALUE_W-1:DIV_SHIFT];
    end
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv_out) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      out_value    <= value;
      out_locked   <= s1_locked;
      out_interval <= s1_interval;
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.channel_value = out_value;
  assign rsp.locked        = out_locked;
  assign rsp.interval      = out_interval;

endmodule
